// ===== rtl/core/lffs_pkg.sv =====
`default_nettype none

package lffs_pkg;

   localparam int TIME_BITS  = 32;
   localparam int VALUE_BITS = 8;

   localparam int FULL_VALUE = (1 << VALUE_BITS) - 1;
   localparam int BASE_VALUE = (FULL_VALUE * 2 + 5) / 10;

   // divisor holds 2 * fade_time_ms or fade_time_ms, 17 bits
   localparam int DVS_W  = 17;
   localparam int PROD_W = VALUE_BITS + DVS_W;
   localparam int DIV_W  = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
   localparam int CNT_W  = $clog2(DIV_W + 1);

   localparam logic [15:0] HUE_RESET    = 16'd0;
   localparam logic [15:0] FADE_RESET   = 16'd850;
   localparam logic [15:0] WAIT_RESET   = 16'd550;
   localparam logic [7:0]  REPEAT_RESET = 8'd3;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_FOUT = 2'd2,
      PH_FIN  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CFG_HUE    = 2'd0,
      CFG_FADE   = 2'd1,
      CFG_WAIT   = 2'd2,
      CFG_REPEAT = 2'd3
   } cfg_index_type;

   typedef enum logic {
      DIV_TIMING = 1'b0,
      DIV_FADE   = 1'b1
   } div_sel_type;

   typedef struct packed {
      logic        start_pulse;
      logic        stop_pulse;
      logic [15:0] delta_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  phase_code;
      logic        color_valid;
      logic [15:0] hue_out;
      logic [7:0]  brightness;
      logic        sequence_done;
      logic [15:0] cycle_index;
   } rsp_type;

   typedef struct packed {
      logic        capture;
      logic        step_time;
      logic        div_start;
      div_sel_type div_sel;
      logic        eval;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic enabled;
      logic fade_active;
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/lffs_div.sv =====
`default_nettype none

module lffs_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [lffs_pkg::DIV_W-1:0] dividend,
   input  wire logic [lffs_pkg::DVS_W-1:0] divisor,
   output logic                            done,
   output logic [lffs_pkg::DIV_W-1:0]      quotient,
   output logic [lffs_pkg::DVS_W-1:0]      remainder
);
   import lffs_pkg::*;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;

   logic [DVS_W:0]   rem_shift;
   logic [DVS_W:0]   trial;
   logic             fits;

   // restoring division, one quotient bit per cycle
   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign trial     = rem_shift - {1'b0, dvs_ff};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= trial[DVS_W-1:0];
         end else begin
            rem_ff <= rem_shift[DVS_W-1:0];
         end
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lffs_datapath.sv =====
`default_nettype none

module lffs_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lffs_pkg::cmd_type    cmd,
   output lffs_pkg::status_type      status,
   input  wire lffs_pkg::req_type    req_word,
   output lffs_pkg::rsp_type         rsp_word,
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_data
);
   import lffs_pkg::*;

   // configuration
   logic [15:0] hue_ff;
   logic [15:0] fade_ff;
   logic [15:0] wait_ff;
   logic [7:0]  repeat_ff;

   // sequencer state
   logic                 latch_ff;
   phase_type            phase_ff;
   logic [TIME_BITS-1:0] elapsed_ff;
   logic [15:0]          iter_ff;
   logic                 done_ff;
   logic                 neg_ff;

   req_type in_ff;
   rsp_type rsp_ff;

   logic                 div_done;
   logic [DIV_W-1:0]     div_quo;
   logic [DVS_W-1:0]     div_rem;
   logic [DIV_W-1:0]     div_dividend;
   logic [DVS_W-1:0]     div_divisor;

   logic [15:0]          fade_eff;
   logic [DVS_W-1:0]     fade_x;
   logic [DVS_W-1:0]     period;
   logic                 latch_next;
   logic [TIME_BITS:0]   time_sum;
   logic [TIME_BITS-1:0] elapsed_new;
   logic [TIME_BITS-1:0] wait_x;
   logic                 reached;
   logic [TIME_BITS-1:0] diff;
   logic                 prog_ge;
   logic                 iter_ge;
   logic [15:0]          iter_sat;
   phase_type            phase_next;
   logic                 latch_eval;
   logic                 done_eval;

   logic [DVS_W-1:0]     term_a;
   logic [DVS_W-1:0]     term_b;
   logic                 neg;
   logic [DVS_W-1:0]     mag;
   logic [PROD_W-1:0]    prod;
   logic [PROD_W-1:0]    bias;

   logic [VALUE_BITS:0]   q_val;
   logic [VALUE_BITS:0]   pos_sum;
   logic [VALUE_BITS-1:0] fade_val;
   logic [VALUE_BITS-1:0] value;
   logic [VALUE_BITS+7:0] value_ext;
   logic                  color_on;

   assign fade_eff = (fade_ff == 16'd0) ? 16'd1 : fade_ff;
   assign fade_x   = {1'b0, fade_eff};
   assign period   = {fade_eff, 1'b0};

   assign latch_next = (latch_ff | in_ff.start_pulse) & ~in_ff.stop_pulse;

   assign time_sum = {1'b0, elapsed_ff} + (TIME_BITS + 1)'(in_ff.delta_ms);
   always_comb begin
      if (phase_ff == PH_IDLE) begin
         elapsed_new = '0;
      end else if (time_sum[TIME_BITS]) begin
         elapsed_new = '1;
      end else begin
         elapsed_new = time_sum[TIME_BITS-1:0];
      end
   end

   assign wait_x  = TIME_BITS'(wait_ff);
   assign reached = elapsed_ff >= wait_x;
   // before the wait ends phase and iteration count as zero
   assign diff    = reached ? (elapsed_ff - wait_x) : '0;

   assign prog_ge  = div_rem >= fade_x;
   assign iter_ge  = div_quo >= DIV_W'(repeat_ff);
   assign iter_sat = (|div_quo[DIV_W-1:16]) ? 16'hFFFF : div_quo[15:0];

   always_comb begin
      phase_next = phase_ff;
      latch_eval = latch_ff;
      done_eval  = 1'b0;
      unique case (phase_ff)
         PH_IDLE, PH_WAIT: begin
            phase_next = reached ? PH_FOUT : PH_WAIT;
         end
         PH_FOUT: begin
            if (prog_ge) begin
               if (iter_ge) begin
                  latch_eval = 1'b0;
                  phase_next = PH_IDLE;
                  done_eval  = 1'b1;
               end else begin
                  phase_next = PH_FIN;
               end
            end
         end
         PH_FIN: begin
            if (!prog_ge) begin
               phase_next = PH_FOUT;
            end
         end
      endcase
   end

   // fade-out uses fade - phase, fade-in phase - fade; negative rounds away from zero
   assign term_a = (phase_ff == PH_FIN) ? div_rem : fade_x;
   assign term_b = (phase_ff == PH_FIN) ? fade_x : div_rem;
   assign neg    = term_a < term_b;
   assign mag    = neg ? (term_b - term_a) : (term_a - term_b);
   assign prod   = PROD_W'({mag, {VALUE_BITS{1'b0}}}) - PROD_W'(mag);
   assign bias   = neg ? PROD_W'(fade_x - 1'b1) : '0;

   always_comb begin
      if (cmd.div_sel == DIV_FADE) begin
         div_dividend = DIV_W'(prod + bias);
         div_divisor  = fade_x;
      end else begin
         div_dividend = DIV_W'(diff);
         div_divisor  = period;
      end
   end

   lffs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // quotient of the fade division never exceeds the full value
   assign q_val   = div_quo[VALUE_BITS:0];
   assign pos_sum = (VALUE_BITS + 1)'(BASE_VALUE) + q_val;
   always_comb begin
      if (neg_ff) begin
         if ((VALUE_BITS + 1)'(BASE_VALUE) >= q_val) begin
            fade_val = VALUE_BITS'((VALUE_BITS + 1)'(BASE_VALUE) - q_val);
         end else begin
            fade_val = '0;
         end
      end else if (pos_sum > (VALUE_BITS + 1)'(FULL_VALUE)) begin
         fade_val = VALUE_BITS'(FULL_VALUE);
      end else begin
         fade_val = pos_sum[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_IDLE:          value = '0;
         PH_WAIT:          value = VALUE_BITS'(FULL_VALUE);
         PH_FOUT, PH_FIN:  value = fade_val;
      endcase
   end

   assign value_ext = (VALUE_BITS + 8)'(value);
   assign color_on  = phase_ff != PH_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff     <= HUE_RESET;
         fade_ff    <= FADE_RESET;
         wait_ff    <= WAIT_RESET;
         repeat_ff  <= REPEAT_RESET;
         latch_ff   <= 1'b0;
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         iter_ff    <= '0;
         done_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CFG_HUE:    hue_ff    <= csr_data;
               CFG_FADE:   fade_ff   <= csr_data;
               CFG_WAIT:   wait_ff   <= csr_data;
               CFG_REPEAT: repeat_ff <= csr_data[7:0];
            endcase
         end
         if (cmd.step_time) begin
            latch_ff <= latch_next;
            done_ff  <= 1'b0;
            if (latch_next) begin
               elapsed_ff <= elapsed_new;
            end else begin
               phase_ff <= PH_IDLE;
            end
         end
         if (cmd.eval) begin
            phase_ff <= phase_next;
            latch_ff <= latch_eval;
            done_ff  <= done_eval;
            iter_ff  <= iter_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_word;
      end
      if (cmd.div_start && cmd.div_sel == DIV_FADE) begin
         neg_ff <= neg;
      end
      if (cmd.load_out) begin
         rsp_ff.phase_code    <= phase_ff;
         rsp_ff.color_valid   <= color_on;
         rsp_ff.hue_out       <= color_on ? hue_ff : 16'd0;
         rsp_ff.brightness    <= value_ext[7:0];
         rsp_ff.sequence_done <= done_ff;
         rsp_ff.cycle_index   <= iter_ff;
      end
   end

   assign status.enabled     = latch_next;
   assign status.fade_active = (phase_ff == PH_FOUT) || (phase_ff == PH_FIN);
   assign status.div_done    = div_done;
   assign rsp_word           = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lffs_ctrl.sv =====
`default_nettype none

module lffs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output lffs_pkg::cmd_type         cmd,
   input  wire lffs_pkg::status_type status
);
   import lffs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TIME,
      S_START1,
      S_DIV1,
      S_EVAL,
      S_FADE,
      S_DIV2,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.div_sel  = DIV_TIMING;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_TIME;
            end
         end
         S_TIME: begin
            cmd.step_time = 1'b1;
            state_in      = status.enabled ? S_START1 : S_OUT;
         end
         S_START1: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV1;
         end
         S_DIV1: begin
            if (status.div_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_FADE;
         end
         S_FADE: begin
            cmd.div_sel = DIV_FADE;
            if (status.fade_active) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV2;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV2: begin
            cmd.div_sel = DIV_FADE;
            if (status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            cmd.div_sel = DIV_FADE;
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/led_flash_fade_sequencer.sv =====
`default_nettype none
// Steps: capture, time step, timing division, evaluation, fade division, output load;
// no fade division in wait or finished sequence; a disabled frame skips both divisions.
// One radix-2 divider is shared by the timing division and the brightness division.
// A new word is taken only in idle, once the last result is in the output register;
// a finished result waits there while the next word is worked on.
// Reset (synchronous, active high) restores configuration defaults, idle state,
// zero elapsed time and iteration count; no clearing pass.
module led_flash_fade_sequencer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lffs_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lffs_pkg::rsp_type      rsp_word,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_data
);
   import lffs_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lffs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   lffs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import lffs_pkg::*;

   typedef enum logic {ROW_FRAME, ROW_CONFIG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      word;
      bit           typed;
      rsp_type      want;
      logic [15:0]  hue;
      logic [15:0]  fade;
      logic [15:0]  hold;
      logic [7:0]   rep;
   } frame_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_word = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_word;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   cfg_index_type csr_index = CFG_HUE;
   logic [15:0]   csr_data = '0;

   // shadow of the sequencer
   logic              seq_enabled;
   phase_type         seq_phase;
   longint unsigned   seq_elapsed;
   logic [15:0]       seq_iter;
   logic [15:0]       cfg_hue, cfg_fade, cfg_hold;
   logic [7:0]        cfg_repeat;

   rsp_type pending_colors[$];
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      fixed_exp_on = 1'b0;
   rsp_type fixed_exp = '0;

   led_flash_fade_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // value channel for a signed fade distance n over fade length f
   function automatic logic [7:0] fade_level(longint n, longint f);
      longint q, v;
      if (n >= 0)
         q = (FULL_VALUE * n) / f;
      else
         q = -((FULL_VALUE * (-n) + f - 1) / f);
      v = BASE_VALUE + q;
      if (v < 0) v = 0;
      if (v > FULL_VALUE) v = FULL_VALUE;
      return v[7:0];
   endfunction

   function automatic rsp_type next_frame_color(req_type w);
      longint unsigned fade, period, tmax, diff, prog, iter;
      rsp_type r;
      r = '0;
      prog = 0;
      iter = 0;
      fade = (cfg_fade == 0) ? 1 : cfg_fade;
      period = 2 * fade;
      tmax = (64'd1 << TIME_BITS) - 1;
      if (w.start_pulse) seq_enabled = 1'b1;
      if (w.stop_pulse) seq_enabled = 1'b0;
      if (!seq_enabled) begin
         seq_phase = PH_IDLE;
      end else begin
         // delta is dropped on the frame that leaves idle
         if (seq_phase == PH_IDLE)
            seq_elapsed = 0;
         else if (seq_elapsed > tmax - w.delta_ms)
            seq_elapsed = tmax;
         else
            seq_elapsed = seq_elapsed + w.delta_ms;
         if (seq_elapsed >= cfg_hold) begin
            diff = seq_elapsed - cfg_hold;
            iter = diff / period;
            prog = diff % period;
         end
         case (seq_phase)
            PH_IDLE, PH_WAIT: seq_phase = (seq_elapsed < cfg_hold) ? PH_WAIT : PH_FOUT;
            PH_FOUT: begin
               if (prog >= fade) begin
                  if (iter >= cfg_repeat) begin
                     seq_enabled = 1'b0;
                     seq_phase = PH_IDLE;
                     r.sequence_done = 1'b1;
                  end else begin
                     seq_phase = PH_FIN;
                  end
               end
            end
            default: if (prog < fade) seq_phase = PH_FOUT;
         endcase
         seq_iter = (iter > 65535) ? 16'hFFFF : iter[15:0];
         case (seq_phase)
            PH_WAIT: begin
               r.color_valid = 1'b1;
               r.brightness = FULL_VALUE[7:0];
            end
            PH_FOUT: begin
               r.color_valid = 1'b1;
               r.brightness = fade_level(longint'(fade) - longint'(prog), longint'(fade));
            end
            PH_FIN: begin
               r.color_valid = 1'b1;
               r.brightness = fade_level(longint'(prog) - longint'(fade), longint'(fade));
            end
            default: ;
         endcase
      end
      r.phase_code = seq_phase;
      r.hue_out = r.color_valid ? cfg_hue : 16'd0;
      r.cycle_index = seq_iter;
      return r;
   endfunction

   function automatic void report_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type e, r;
      if (reset) begin
         seq_enabled = 1'b0;
         seq_phase = PH_IDLE;
         seq_elapsed = 0;
         seq_iter = '0;
         cfg_hue = HUE_RESET;
         cfg_fade = FADE_RESET;
         cfg_hold = WAIT_RESET;
         cfg_repeat = REPEAT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CFG_HUE:    cfg_hue = csr_data;
               CFG_FADE:   cfg_fade = csr_data;
               CFG_WAIT:   cfg_hold = csr_data;
               CFG_REPEAT: cfg_repeat = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            r = next_frame_color(req_word);
            pending_colors.push_back(fixed_exp_on ? fixed_exp : r);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_colors.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none got %0h", $time, rsp_word);
            end else begin
               e = pending_colors.pop_front();
               report_field("phase_code", 16'(e.phase_code), 16'(rsp_word.phase_code));
               report_field("color_valid", 16'(e.color_valid), 16'(rsp_word.color_valid));
               report_field("hue_out", e.hue_out, rsp_word.hue_out);
               report_field("brightness", 16'(e.brightness), 16'(rsp_word.brightness));
               report_field("sequence_done", 16'(e.sequence_done),
                            16'(rsp_word.sequence_done));
               report_field("cycle_index", e.cycle_index, rsp_word.cycle_index);
            end
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_frame(req_type w, bit typed, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      fixed_exp_on = typed;
      fixed_exp = want;
      req_word <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      fixed_exp_on = 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic csr_write(cfg_index_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_config(logic [15:0] hue, logic [15:0] fade, logic [15:0] hold,
                             logic [7:0] rep);
      csr_write(CFG_HUE, hue);
      csr_write(CFG_FADE, fade);
      csr_write(CFG_WAIT, hold);
      csr_write(CFG_REPEAT, {8'd0, rep});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_delta();
      int unsigned span, sel, d;
      span = (cfg_fade == 0) ? 1 : cfg_fade;
      span = span + cfg_hold;
      sel = $urandom_range(99);
      if (sel < 10)
         d = 0;
      else if (sel < 55)
         d = $urandom_range(span / 8 + 1);
      else if (sel < 85)
         d = $urandom_range(2 * span);
      else
         d = $urandom_range(16'hFFFF);
      if (d > 65535) d = 65535;
      return d[15:0];
   endfunction

   // mostly start-led sequences of random frames, some stray frames between them
   task automatic run_random(int n_items);
      int count, seq_len;
      req_type w;
      count = 0;
      while (count < n_items) begin
         if ($urandom_range(99) < 15) begin
            w.start_pulse = 1'b0;
            w.stop_pulse = 1'($urandom_range(1));
            w.delta_ms = 16'($urandom_range(16'hFFFF));
            send_frame(w, 1'b0, '0);
            count++;
         end
         w.start_pulse = 1'b1;
         w.stop_pulse = ($urandom_range(19) == 0);
         w.delta_ms = 16'($urandom_range(16'hFFFF));
         send_frame(w, 1'b0, '0);
         count++;
         seq_len = $urandom_range(4, 40);
         for (int j = 0; j < seq_len; j++) begin
            w.start_pulse = ($urandom_range(29) == 0);
            w.stop_pulse = ($urandom_range(49) == 0);
            w.delta_ms = pick_delta();
            send_frame(w, 1'b0, '0);
            count++;
         end
         if ($urandom_range(99) < 8) drain();
      end
   endtask

   function automatic frame_row_type frm(logic s, logic p, logic [15:0] d);
      frame_row_type r;
      r.kind = ROW_FRAME;
      r.word.start_pulse = s;
      r.word.stop_pulse = p;
      r.word.delta_ms = d;
      r.typed = 1'b0;
      r.want = '0;
      r.hue = '0;
      r.fade = '0;
      r.hold = '0;
      r.rep = '0;
      return r;
   endfunction

   function automatic frame_row_type chk(logic s, logic p, logic [15:0] d, rsp_type want);
      frame_row_type r;
      r = frm(s, p, d);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic frame_row_type cfg_row(logic [15:0] hue, logic [15:0] fade,
                                             logic [15:0] hold, logic [7:0] rep);
      frame_row_type r;
      r = frm(1'b0, 1'b0, 16'd0);
      r.kind = ROW_CONFIG;
      r.hue = hue;
      r.fade = fade;
      r.hold = hold;
      r.rep = rep;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(phase_type p, logic v, logic [15:0] h, logic [7:0] b,
                                      logic dn, logic [15:0] c);
      rsp_type r;
      r.phase_code = p;
      r.color_valid = v;
      r.hue_out = h;
      r.brightness = b;
      r.sequence_done = dn;
      r.cycle_index = c;
      return r;
   endfunction

   initial begin
      frame_row_type rows[$];
      logic [15:0]   h, f, w;
      logic [7:0]    rp;

      // reset defaults: hue 0, fade 850, hold 550, repeat 3
      rows.push_back(chk(1'b0, 1'b0, 16'hFFFF,
                         mk_rsp(PH_IDLE, 1'b0, 16'd0, 8'd0, 1'b0, 16'd0)));
      // delta is dropped on the start frame
      rows.push_back(chk(1'b1, 1'b0, 16'hFFFF,
                         mk_rsp(PH_WAIT, 1'b1, 16'd0, 8'd255, 1'b0, 16'd0)));
      rows.push_back(chk(1'b0, 1'b0, 16'd0,
                         mk_rsp(PH_WAIT, 1'b1, 16'd0, 8'd255, 1'b0, 16'd0)));
      rows.push_back(chk(1'b0, 1'b0, 16'd549,
                         mk_rsp(PH_WAIT, 1'b1, 16'd0, 8'd255, 1'b0, 16'd0)));
      rows.push_back(frm(1'b0, 1'b0, 16'd1));
      rows.push_back(frm(1'b0, 1'b0, 16'd425));
      rows.push_back(frm(1'b0, 1'b0, 16'd425));
      rows.push_back(frm(1'b0, 1'b0, 16'd850));
      rows.push_back(frm(1'b0, 1'b0, 16'hFFFF));
      // start and stop together: stop wins
      rows.push_back(frm(1'b1, 1'b1, 16'd5));
      rows.push_back(frm(1'b1, 1'b0, 16'd0));
      rows.push_back(chk(1'b0, 1'b1, 16'd100,
                         mk_rsp(PH_IDLE, 1'b0, 16'd0, 8'd0, 1'b0, 16'd0)));
      // zero fade acts as one, zero hold, zero repeat
      rows.push_back(cfg_row(16'hFFFF, 16'd0, 16'd0, 8'd0));
      rows.push_back(chk(1'b1, 1'b0, 16'd7,
                         mk_rsp(PH_FOUT, 1'b1, 16'hFFFF, 8'd255, 1'b0, 16'd0)));
      rows.push_back(chk(1'b0, 1'b0, 16'd1,
                         mk_rsp(PH_IDLE, 1'b0, 16'd0, 8'd0, 1'b1, 16'd0)));
      rows.push_back(frm(1'b1, 1'b0, 16'd0));
      rows.push_back(frm(1'b0, 1'b0, 16'hFFFF));
      // big step lands past the end of fade-out: value clamps at zero
      rows.push_back(cfg_row(16'h1234, 16'd100, 16'd10, 8'd255));
      rows.push_back(frm(1'b1, 1'b0, 16'd0));
      rows.push_back(frm(1'b0, 1'b0, 16'd160));
      rows.push_back(frm(1'b0, 1'b0, 16'd30));
      // iteration count saturates
      rows.push_back(cfg_row(16'h8000, 16'd1, 16'd0, 8'd255));
      rows.push_back(frm(1'b1, 1'b0, 16'd0));
      rows.push_back(frm(1'b0, 1'b0, 16'hFFFE));
      rows.push_back(frm(1'b0, 1'b0, 16'hFFFE));
      rows.push_back(frm(1'b0, 1'b0, 16'hFFFE));
      rows.push_back(frm(1'b0, 1'b0, 16'd1));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 25;
      recv_idle_pct = 70;
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CONFIG) begin
            drain();
            set_config(rows[i].hue, rows[i].fade, rows[i].hold, rows[i].rep);
         end else begin
            send_frame(rows[i].word, rows[i].typed, rows[i].want);
         end
      end

      for (int k = 0; k < 9; k++) begin
         drain();
         case (k)
            0: begin h = 16'($urandom); f = 16'd850; w = 16'd550; rp = 8'd3; end
            1: begin h = 16'hFFFF; f = 16'd1; w = 16'd0; rp = 8'd0; end
            2: begin h = 16'd0; f = 16'hFFFF; w = 16'hFFFF; rp = 8'hFF; end
            4: begin
               h = 16'($urandom);
               f = 16'd0;
               w = 16'($urandom_range(200));
               rp = 8'($urandom_range(3));
            end
            5: begin h = 16'($urandom); f = 16'd3; w = 16'd5; rp = 8'hFF; end
            default: begin
               h = 16'($urandom);
               f = 16'($urandom_range(1, 2000));
               w = 16'($urandom_range(3000));
               rp = 8'($urandom_range(7));
            end
         endcase
         if (k < 3) begin
            send_idle_pct = 25;
            recv_idle_pct = 70;
         end else if (k < 6) begin
            send_idle_pct = 70;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_config(h, f, w, rp);
         run_random(211);
      end

      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
